FILE: hw/rtl/mtt_pkg.sv
`default_nettype none

package mtt_pkg;

    // Field widths
    localparam int MAC_W  = 48;
    localparam int SIG_W  = 8;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 4;
    localparam int MASK_W = 8;

    // Stream payload widths
    localparam int S_TDATA_W = MAC_W + SIG_W + TIME_W;
    localparam int M_TDATA_W = 24;

    // Operation codes, carried on s_tuser
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;

    // Highest expired count reported
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [SIG_W-1:0]  sig;
        logic [TIME_W-1:0] seen;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan_en;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mtt_ctrl.sv
`default_nettype none

module mtt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mtt_pkg::dp_status_t status,
    output mtt_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Sequencer: scan every entry, let the last read settle, then commit
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.commit   = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted request always starts a scan
    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    // A result is only loaded into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over a waiting result");

    // A stalled finish holds its place
    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !status.out_free) |=> (state_reg == ST_FINISH))
        else $error("finish left while output was stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/mtt_datapath.sv
`default_nettype none

module mtt_datapath #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire mtt_pkg::ctrl_cmd_t               cmd,
    output mtt_pkg::dp_status_t                   status,
    input  wire logic [mtt_pkg::TIME_W-1:0]       timeout_ms,
    input  wire logic [mtt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mtt_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SEXT_W = (IDX_W > mtt_pkg::SLOT_W) ? IDX_W : mtt_pkg::SLOT_W;
    localparam int PEXT_W = (TABLE_ENTRIES > mtt_pkg::MASK_W) ? TABLE_ENTRIES
                                                              : mtt_pkg::MASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Entry memory, one write and one registered read a cycle
    mtt_pkg::entry_t mem [TABLE_ENTRIES];

    // Item under work
    logic                        op_reg;
    logic [mtt_pkg::MAC_W-1:0]   mac_reg;
    logic [mtt_pkg::SIG_W-1:0]   sig_reg;
    logic [mtt_pkg::TIME_W-1:0]  now_reg;

    // Scan pipeline
    logic [IDX_W-1:0]            addr_reg, addr_next;
    logic                        rd_vld_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    mtt_pkg::entry_t             rd_data_reg;
    logic                        rd_ent_vld_reg;

    // Per-entry flags
    logic [TABLE_ENTRIES-1:0]    valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0]    pending_reg, pending_next;

    // Scan results
    logic                        match_found_reg, match_found_next;
    logic [IDX_W-1:0]            match_idx_reg, match_idx_next;
    logic                        free_found_reg, free_found_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [mtt_pkg::CNT_W-1:0]   exp_cnt_reg, exp_cnt_next;

    // Output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [mtt_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    mtt_pkg::entry_t             cur;
    logic                        is_match;
    logic                        is_free;
    logic                        aged;
    logic [mtt_pkg::TIME_W-1:0]  age;
    logic [IDX_W-1:0]            pick;
    logic [SEXT_W-1:0]           pick_ext;
    logic [PEXT_W-1:0]           pend_ext;
    logic                        overwrote;
    logic                        age_wr;
    logic                        obs_wr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    mtt_pkg::entry_t             wr_data;

    assign status.scan_last = (addr_reg == LAST_IDX);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= s_tuser[0];
            mac_reg <= s_tdata[mtt_pkg::MAC_W-1:0];
            sig_reg <= s_tdata[mtt_pkg::MAC_W +: mtt_pkg::SIG_W];
            now_reg <= s_tdata[mtt_pkg::MAC_W + mtt_pkg::SIG_W +: mtt_pkg::TIME_W];
        end
    end

    // Scan address counter
    always_comb begin
        addr_next = addr_reg;
        priority if (cmd.load_item) begin
            addr_next = '0;
        end else if (cmd.scan_en) begin
            addr_next = addr_reg + 1'b1;
        end else begin
            addr_next = addr_reg;
        end
    end

    // Entry as seen by the compare stage; an invalid entry reads as cleared
    assign cur      = rd_ent_vld_reg ? rd_data_reg : '0;
    assign is_match = (cur.mac == mac_reg);
    assign is_free  = (cur.mac[mtt_pkg::MAC_W-1 -: 8] == 8'd0);
    assign age      = now_reg - cur.seen;
    assign aged     = (cur.seen != '0) && (age > timeout_ms);

    // Accumulate lookup and aging results one entry a cycle
    always_comb begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        exp_cnt_next     = exp_cnt_reg;
        priority if (cmd.load_item) begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            exp_cnt_next     = '0;
        end else if (rd_vld_reg) begin
            if (op_reg == mtt_pkg::OP_OBSERVE) begin
                if (is_match) begin
                    match_found_next = 1'b1;
                    match_idx_next   = rd_idx_reg;
                end
                if (is_free && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
            end else if (aged && exp_cnt_reg != mtt_pkg::CNT_MAX) begin
                exp_cnt_next = exp_cnt_reg + 1'b1;
            end
        end else begin
            exp_cnt_next = exp_cnt_reg;
        end
    end

    // Chosen entry: last match, else first free, else the last entry
    always_comb begin
        overwrote = 1'b0;
        priority if (match_found_reg) begin
            pick = match_idx_reg;
        end else if (free_found_reg) begin
            pick = free_idx_reg;
        end else begin
            pick      = LAST_IDX;
            overwrote = 1'b1;
        end
    end

    assign pick_ext = SEXT_W'(pick);
    assign pend_ext = PEXT_W'(pending_reg);

    // Memory write port: aging during a tick scan, update on observe commit
    assign age_wr  = rd_vld_reg && (op_reg == mtt_pkg::OP_TICK) && aged;
    assign obs_wr  = cmd.commit && (op_reg == mtt_pkg::OP_OBSERVE);
    assign wr_en   = age_wr || obs_wr;
    assign wr_addr = obs_wr ? pick : rd_idx_reg;

    always_comb begin
        if (obs_wr) begin
            wr_data.mac  = mac_reg;
            wr_data.sig  = sig_reg;
            wr_data.seen = now_reg;
        end else begin
            wr_data.mac  = {8'd0, cur.mac[mtt_pkg::MAC_W-9:0]};
            wr_data.sig  = cur.sig;
            wr_data.seen = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg    <= mem[addr_reg];
        rd_ent_vld_reg <= valid_reg[addr_reg];
        rd_idx_reg     <= addr_reg;
    end

    // Valid and pending flags
    always_comb begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        if (obs_wr) begin
            valid_next[pick]   = 1'b1;
            pending_next[pick] = 1'b1;
        end
        if (cmd.commit && op_reg == mtt_pkg::OP_TICK) begin
            pending_next = '0;
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Result word for the request being finished
    always_comb begin
        m_tdata_next = '0;
        if (op_reg == mtt_pkg::OP_OBSERVE) begin
            m_tdata_next[2:0] = pick_ext[mtt_pkg::SLOT_W-1:0];
            m_tdata_next[3]   = match_found_reg;
            m_tdata_next[4]   = overwrote;
        end else begin
            m_tdata_next[8:5]  = exp_cnt_reg;
            m_tdata_next[16:9] = pend_ext[mtt_pkg::MASK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            valid_reg       <= '0;
            pending_reg     <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            exp_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            addr_reg        <= addr_next;
            rd_vld_reg      <= cmd.scan_en;
            valid_reg       <= valid_next;
            pending_reg     <= pending_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            exp_cnt_reg     <= exp_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An observe commit leaves its entry pending
    a_obs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        obs_wr |=> pending_reg[$past(pick)])
        else $error("observed entry not marked pending");

    // Expired count never exceeds the table size
    a_exp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(exp_cnt_reg) <= TABLE_ENTRIES)
        else $error("expired count beyond table size");

endmodule

`default_nettype wire

FILE: hw/rtl/mac_tracking_table_with_aging.sv
// MAC tracking table with aging.
// Input stream s_*: one request per handshake. s_tuser selects observe (0)
// or tick (1); s_tdata carries the MAC, signal strength and time.
// Result stream m_*: exactly one result per request, in request order.
// An observe finds its MAC (highest matching entry), else the lowest free
// entry, else the last entry, and stores MAC, signal and time there.
// A tick frees entries older than timeout_ms and reports and clears the
// pending mask.
// Each request scans the entry memory through its single read port, one
// entry a cycle; the next request is taken only after the previous one
// has been committed. s_tready is high whenever no request is being
// worked on, also while a result still waits in the output register.
// When a result waits in the output register and m_tready is low, the
// finished request holds until it frees; no new request is taken meanwhile.
// Reset clears the table (per-entry valid bits), the pending mask, both
// streams, and sets timeout_ms (APB address 0) to 300000.
`default_nettype none

module mac_tracking_table_with_aging #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [47:0] mac_address, [55:48] signal_strength, [87:56] now_ms
    input  wire logic [mtt_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] operation
    input  wire logic [0:0]                        s_tuser,

    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] slot, [3] hit, [4] overwrote, [8:5] expired_count,
    // [16:9] pending_mask, [23:17] zero
    output logic [mtt_pkg::M_TDATA_W-1:0]          m_tdata,

    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mtt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [mtt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mtt_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    mtt_pkg::ctrl_cmd_t          cmd;
    mtt_pkg::dp_status_t         status;
    logic [mtt_pkg::TIME_W-1:0]  timeout_reg;
    logic                        reg_sel;
    logic                        cfg_wr;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[mtt_pkg::CFG_ADDR_W-1] == mtt_pkg::REG_TIMEOUT);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_sel ? timeout_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= mtt_pkg::TIMEOUT_RESET;
        end else if (cfg_wr && reg_sel) begin
            timeout_reg <= pwdata;
        end
    end

    mtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mtt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .timeout_ms (timeout_reg),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: bench/mac_tracking_table_with_aging_test.sv
`timescale 1ns / 1ps

module mac_tracking_table_with_aging_test;

    import mtt_pkg::*;

    localparam int ENTRIES = 8;
    localparam int POOL_SIZE = 12;
    localparam int ENTRY_IDX_W = $clog2(ENTRIES);
    localparam int POOL_IDX_W = $clog2(POOL_SIZE);
    localparam int LATENCY = ENTRIES + 3;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'(4 * REG_TIMEOUT);

    typedef struct packed {
        logic              op;
        logic [MAC_W-1:0]  mac;
        logic [SIG_W-1:0]  sig;
        logic [TIME_W-1:0] now;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              overwrote;
        logic [CNT_W-1:0]  expired;
        logic [MASK_W-1:0] pending;
    } outcome_t;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn;
    always #5 aclk = ~aclk;

    // DUT connections
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [47:0] mac, [55:48] signal, [87:56] now_ms
    logic [0:0]            s_tuser;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // [2:0] slot, [3] hit, [4] overwrote,
                                      // [8:5] expired, [16:9] pending mask
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mac_tracking_table_with_aging #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table
    logic [MAC_W-1:0]  tbl_mac  [ENTRIES];
    logic [TIME_W-1:0] tbl_seen [ENTRIES];
    logic [SIG_W-1:0]  tbl_sig  [ENTRIES];
    logic              tbl_pend [ENTRIES];
    logic [TIME_W-1:0] timeout_shadow;

    outcome_t          outcome_q[$];
    int                err_count = 0;
    bit                no_gaps = 1'b0;
    int                stall_left = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
    outcome_t          want;
    outcome_t          got;

    // Table update for one request, returns the result it should produce
    function automatic outcome_t apply_request(request_t rq);
        outcome_t          res;
        int                pick;
        int                i;
        logic [TIME_W-1:0] age;
        res = '0;
        pick = -1;
        if (rq.op == OP_OBSERVE) begin
            // highest matching entry wins
            for (i = 0; i < ENTRIES; i++)
                if (tbl_mac[i] == rq.mac) pick = i;
            if (pick >= 0) begin
                res.hit = 1'b1;
            end else begin
                for (i = 0; i < ENTRIES && pick < 0; i++)
                    if (tbl_mac[i][MAC_W-1 -: 8] == 8'h00) pick = i;
                if (pick < 0) begin
                    pick = ENTRIES - 1;
                    res.overwrote = 1'b1;
                end
            end
            tbl_mac[pick]  = rq.mac;
            tbl_sig[pick]  = rq.sig;
            tbl_seen[pick] = rq.now;
            tbl_pend[pick] = 1'b1;
            res.slot = pick[SLOT_W-1:0];
        end else begin
            // age out, then report and clear pending bits
            for (i = 0; i < ENTRIES; i++) begin
                age = rq.now - tbl_seen[i];
                if (tbl_seen[i] != '0 && age > timeout_shadow) begin
                    tbl_seen[i] = '0;
                    tbl_mac[i][MAC_W-1 -: 8] = 8'h00;
                    if (res.expired != CNT_MAX) res.expired = res.expired + 1'b1;
                end
                if (tbl_pend[i]) begin
                    if (i < MASK_W) res.pending[i] = 1'b1;
                    tbl_pend[i] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_val, act_val, $realtime);
    endtask

    // Sender: one request, with a random hold-off before it
    task automatic send_request(request_t rq);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {rq.now, rq.sig, rq.mac};
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(apply_request(rq));
    endtask

    task automatic observe(logic [MAC_W-1:0] mac, logic [SIG_W-1:0] sig, logic [TIME_W-1:0] now);
        send_request('{op: OP_OBSERVE, mac: mac, sig: sig, now: now});
    endtask

    task automatic tick(logic [TIME_W-1:0] now);
        send_request('{op: OP_TICK, mac: MAC_W'({$urandom, $urandom}),
                       sig: SIG_W'($urandom), now: now});
    endtask

    // Drop valid and wait for every outstanding result plus the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == TIMEOUT_ADDR) timeout_shadow = data;
    endtask

    task automatic cfg_check(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] exp_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== exp_val) report_mismatch("timeout_ms readback", exp_val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timeout(logic [TIME_W-1:0] value);
        settle();
        cfg_write(TIMEOUT_ADDR, value);
        cfg_check(TIMEOUT_ADDR, value);
    endtask

    // Result side: random back-pressure and field-by-field compare
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.slot      = m_tdata[2:0];
            got.hit       = m_tdata[3];
            got.overwrote = m_tdata[4];
            got.expired   = m_tdata[8:5];
            got.pending   = m_tdata[16:9];
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no request outstanding", '0, m_tdata);
            end else begin
                want = outcome_q.pop_front();
                if (got.slot !== want.slot) report_mismatch("slot", want.slot, got.slot);
                if (got.hit !== want.hit) report_mismatch("hit", want.hit, got.hit);
                if (got.overwrote !== want.overwrote)
                    report_mismatch("overwrote", want.overwrote, got.overwrote);
                if (got.expired !== want.expired)
                    report_mismatch("expired_count", want.expired, got.expired);
                if (got.pending !== want.pending)
                    report_mismatch("pending_mask", want.pending, got.pending);
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 3);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_tready <= (stall_left == 0);
    end

    // Reset contents: default timeout, all-zero table, so MAC zero hits the last entry
    task automatic test_after_reset();
        cfg_check(TIMEOUT_ADDR, TIMEOUT_RESET);
        tick(32'd0);
        observe(48'h0, 8'h80, 32'd1);
        tick(32'd2);
    endtask

    // Fill every entry, then force reuse of the last one
    task automatic test_fill_and_overwrite();
        set_timeout(32'd1000);
        observe(48'hFF_FFFF_FFFF_FF, 8'h7F, 32'd10);
        observe(48'h80_0000_0000_01, 8'h80, 32'd10);
        observe(48'h01_0203_0405_06, 8'hC4, 32'd10);
        observe(48'h7E_5555_AAAA_55, 8'h00, 32'd10);
        observe(48'h10_0000_0000_00, 8'hFF, 32'd10);
        observe(48'hA5_A5A5_A5A5_A5, 8'h01, 32'd10);
        observe(48'h5A_5A5A_5A5A_5A, 8'hD8, 32'd10);
        observe(48'hC0_FFEE_0000_07, 8'hB0, 32'd10);
        observe(48'h01_2345_6789_0A, 8'hA0, 32'd10);
        observe(48'hFF_FFFF_FFFF_FF, 8'h3C, 32'd20);
        tick(32'd20);
    endtask

    // Age boundary, cleared first octets, zero time, and wrap of the clock
    task automatic test_aging();
        set_timeout(32'd100);
        tick(32'd110);
        tick(32'd111);
        observe(48'h00_0000_0000_01, 8'hE2, 32'd112);
        observe(48'h00_ABCD_EF01_23, 8'h11, 32'd113);
        observe(48'h42_0000_0000_42, 8'h22, 32'd0);
        tick(32'hFFFF_0000);
        observe(48'h33_4455_6677_88, 8'h9C, 32'hFFFF_FFF0);
        tick(32'h0000_0054);
        tick(32'h0000_0055);
    endtask

    function automatic request_t random_request(logic [TIME_W-1:0] step);
        request_t    rq;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll <= 5)      clock_ms = clock_ms + $urandom_range(0, step);
        else if (roll <= 7) clock_ms = clock_ms + step * 2;
        else if (roll == 8) clock_ms = $urandom;
        else                clock_ms = clock_ms + 1;
        rq.op  = ($urandom_range(0, 4) == 0) ? OP_TICK : OP_OBSERVE;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            rq.mac = mac_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
        else if (roll == 7)
            rq.mac = tbl_mac[ENTRY_IDX_W'($urandom_range(0, ENTRIES - 1))];
        else
            rq.mac = MAC_W'({$urandom, $urandom});
        rq.sig = SIG_W'($urandom);
        rq.now = clock_ms;
        return rq;
    endfunction

    // Random traffic over a small MAC pool, several timeout settings
    task automatic test_random_traffic();
        logic [TIME_W-1:0] timeouts [6];
        logic [TIME_W-1:0] step;
        int                p;
        int                n;
        timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd37, 32'd300000,
                     32'($urandom_range(1, 5000)), 32'($urandom)};
        for (p = 0; p < 6; p++) begin
            set_timeout(timeouts[p]);
            no_gaps = (p == 3);
            if (timeouts[p] == 0)                 step = 32'd16;
            else if (timeouts[p] > 32'h1000_0000) step = 32'h4000_0000;
            else                                  step = timeouts[p] / 3 + 1;
            for (n = 0; n < POOL_SIZE; n++) begin
                mac_pool[n] = MAC_W'({$urandom, $urandom});
                if ($urandom_range(0, 3) == 0) mac_pool[n][MAC_W-1 -: 8] = 8'h00;
            end
            for (n = 0; n < 140; n++) send_request(random_request(step));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        foreach (tbl_mac[i]) begin
            tbl_mac[i]  = '0;
            tbl_seen[i] = '0;
            tbl_sig[i]  = '0;
            tbl_pend[i] = 1'b0;
        end
        timeout_shadow = TIMEOUT_RESET;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_fill_and_overwrite();
        test_aging();
        test_random_traffic();
        settle();

        if (err_count == 0) begin
            $display("mac_tracking_table_with_aging_test passed");
        end else begin
            $display("mac_tracking_table_with_aging_test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("mac_tracking_table_with_aging_test failed");
        $finish;
    end

endmodule

FILE: mac_tracking_table_with_aging.f
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_ctrl.sv
hw/rtl/mtt_datapath.sv
hw/rtl/mac_tracking_table_with_aging.sv
bench/mac_tracking_table_with_aging_test.sv
